// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int PRIO_W      = 16;
  localparam int TAG_W       = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_POLL  = 2'd1,
    OP_PEEK  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } spq_cmd_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// Controller: request sequencing and the result valid flag.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.capture   = 1'b0;
    cmd.exec      = 1'b0;
    in_stall      = 1'b1;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        // hold the request until the result register is free
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spq_pkg::S_IDLE;
        end
      end
      default: state_nxt = spq_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_capture_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == spq_pkg::S_EXEC)
    else $error("accepted request did not enter execution");
  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/spq_dp.sv =====
// Datapath: sorted entry cells, request register and result register.
module spq_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  spq_pkg::spq_cmd_t                       cmd,
  input  logic [spq_pkg::OP_W-1:0]                in_operation,
  input  logic signed [spq_pkg::PRIO_W-1:0]       in_new_priority,
  input  logic [spq_pkg::TAG_W-1:0]               in_new_tag,
  output logic [spq_pkg::STATUS_W-1:0]            out_status,
  output logic [spq_pkg::TAG_W-1:0]               out_result_tag,
  output logic                                    out_head_valid,
  output logic [spq_pkg::TAG_W-1:0]               out_head_tag,
  output logic [spq_pkg::COUNT_OUT_W-1:0]         out_entry_count
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::CNT_W;

  logic signed [spq_pkg::PRIO_W-1:0] prio_r [CAP];
  logic signed [spq_pkg::PRIO_W-1:0] prio_nxt [CAP];
  logic [spq_pkg::TAG_W-1:0]         tag_r [CAP];
  logic [spq_pkg::TAG_W-1:0]         tag_nxt [CAP];
  logic [CW-1:0]                     count_r, count_nxt;

  logic [spq_pkg::OP_W-1:0]          op_r;
  logic signed [spq_pkg::PRIO_W-1:0] req_prio_r;
  logic [spq_pkg::TAG_W-1:0]         req_tag_r;

  logic [spq_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [spq_pkg::TAG_W-1:0]         res_tag_r, res_tag_nxt;
  logic                              head_valid_r;
  logic [spq_pkg::TAG_W-1:0]         head_tag_r;
  logic [spq_pkg::COUNT_OUT_W-1:0]   entry_count_r;

  logic [CAP-1:0] ge;
  logic           full, empty;

  assign full  = count_r == CW'(CAP);
  assign empty = count_r == '0;

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ge[i] = (CW'(i) < count_r) && (prio_r[i] >= req_prio_r);
    end
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      prio_nxt[i] = prio_r[i];
      tag_nxt[i]  = tag_r[i];
    end
    count_nxt   = count_r;
    status_nxt  = spq_pkg::ST_OK;
    res_tag_nxt = '0;
    case (op_r)
      spq_pkg::OP_OFFER: begin
        res_tag_nxt = req_tag_r;
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          if (!ge[0]) begin
            prio_nxt[0] = req_prio_r;
            tag_nxt[0]  = req_tag_r;
          end
          for (int i = 1; i < CAP; i++) begin
            if (!ge[i]) begin
              if (ge[i-1]) begin
                prio_nxt[i] = req_prio_r;
                tag_nxt[i]  = req_tag_r;
              end else begin
                prio_nxt[i] = prio_r[i-1];
                tag_nxt[i]  = tag_r[i-1];
              end
            end
          end
        end
      end
      spq_pkg::OP_POLL: begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          res_tag_nxt = tag_r[0];
          count_nxt   = count_r - CW'(1);
          for (int i = 0; i < CAP - 1; i++) begin
            prio_nxt[i] = prio_r[i+1];
            tag_nxt[i]  = tag_r[i+1];
          end
        end
      end
      default: begin
        if (!empty) res_tag_nxt = tag_r[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      req_prio_r <= in_new_priority;
      req_tag_r  <= in_new_tag;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAP; i++) begin
        prio_r[i] <= prio_nxt[i];
        tag_r[i]  <= tag_nxt[i];
      end
      status_r      <= status_nxt;
      res_tag_r     <= res_tag_nxt;
      head_valid_r  <= count_nxt != '0;
      head_tag_r    <= (count_nxt != '0) ? tag_nxt[0] : '0;
      entry_count_r <= spq_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_status      = status_r;
  assign out_result_tag  = res_tag_r;
  assign out_head_valid  = head_valid_r;
  assign out_head_tag    = head_tag_r;
  assign out_entry_count = entry_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("entry count above capacity");
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> prio_r[0] >= prio_r[1])
    else $error("head cells out of order");
  a_offer_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == spq_pkg::OP_OFFER && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted offer did not grow the queue");
`endif

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: an operation
//   (offer, poll, peek; code 3 acts as peek), a signed priority and a tag.
//   Result channel (out_valid / out_stall) returns one result per request:
//   status, the tag offered / removed / peeked, the head after the request
//   and the entry count after it.
//   Entries are held sorted in a row of shift cells, highest priority at
//   cell 0; equal priorities leave in arrival order. All cells compare
//   against the new priority in the same cycle, so an offer or a poll
//   completes in one execute step.
//   After the accepting edge, the next edge executes the request into the
//   result register when it is free, and out_valid rises with it. A new
//   request is not accepted until the previous one has executed, as set by
//   the capture/execute sequence of the controller.
//   Stall: the result register holds while out_stall is high; a new request
//   is still captured, then waits in execute until the result is taken.
//   Reset (rst_n low, synchronous): the queue empties and no result is
//   pending; cell contents are left as they are and never read.
module sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [spq_pkg::OP_W-1:0]            in_operation,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_new_priority,
  input  logic [spq_pkg::TAG_W-1:0]           in_new_tag,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic [spq_pkg::TAG_W-1:0]           out_result_tag,
  output logic                                out_head_valid,
  output logic [spq_pkg::TAG_W-1:0]           out_head_tag,
  output logic [spq_pkg::COUNT_OUT_W-1:0]     out_entry_count
);

  // commands from the sequencer to the cells
  spq_pkg::spq_cmd_t cmd;

  // sequence each request: capture, then execute once the result slot frees
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // hold the sorted cells and the result register
  spq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_new_priority (in_new_priority),
    .in_new_tag      (in_new_tag),
    .out_status      (out_status),
    .out_result_tag  (out_result_tag),
    .out_head_valid  (out_head_valid),
    .out_head_tag    (out_head_tag),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== tb/sv/spq_result_checker.sv =====
// Checker for the sorted priority queue: tracks accepted requests, predicts each result, compares.
module spq_result_checker
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [PRIO_W-1:0] in_new_priority,
  input  logic [TAG_W-1:0]         in_new_tag,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic [TAG_W-1:0]         out_result_tag,
  input  logic                     out_head_valid,
  input  logic [TAG_W-1:0]         out_head_tag,
  input  logic [COUNT_OUT_W-1:0]   out_entry_count,
  output int                       pending_results,
  output int                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [TAG_W-1:0]       result_tag;
    logic                   head_valid;
    logic [TAG_W-1:0]       head_tag;
    logic [COUNT_OUT_W-1:0] entry_count;
  } queue_result_t;

  // Shadow copy of the sorted row, highest priority at slot 0.
  logic signed [PRIO_W-1:0] prio_slots [CAPACITY];
  logic [TAG_W-1:0]         tag_slots  [CAPACITY];
  int                       held = 0;

  queue_result_t queued_results [$];
  int            mismatches = 0;

  assign fail_count = mismatches;

  function automatic queue_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic signed [PRIO_W-1:0] prio,
                                                  input logic [TAG_W-1:0] tag);
    queue_result_t r;
    int slot;
    int i;
    r = '0;
    if (op == OP_OFFER) begin
      r.result_tag = tag;
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // Go past every entry of equal or higher priority so ties keep arrival order.
        slot = 0;
        while (slot < held && prio_slots[slot] >= prio) slot++;
        for (i = held; i > slot; i--) begin
          prio_slots[i] = prio_slots[i-1];
          tag_slots[i]  = tag_slots[i-1];
        end
        prio_slots[slot] = prio;
        tag_slots[slot]  = tag;
        held++;
      end
    end else if (op == OP_POLL) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.result_tag = tag_slots[0];
        for (i = 1; i < held; i++) begin
          prio_slots[i-1] = prio_slots[i];
          tag_slots[i-1]  = tag_slots[i];
        end
        held--;
      end
    end else begin
      // Peek, and the unused code that behaves as peek.
      if (held != 0) r.result_tag = tag_slots[0];
    end
    r.head_valid  = (held != 0);
    r.head_tag    = (held != 0) ? tag_slots[0] : '0;
    r.entry_count = COUNT_OUT_W'(held);
    return r;
  endfunction

  task automatic compare_field(input string field_name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held = 0;
      queued_results.delete();
    end else begin
      // Compare before pushing so a fresh request never matches an older result.
      if (out_valid && !out_stall) begin
        if (queued_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual tag %0h", $time, out_result_tag);
          mismatches++;
        end else begin
          want = queued_results.pop_front();
          compare_field("status", TAG_W'(want.status), TAG_W'(out_status));
          compare_field("result_tag", want.result_tag, out_result_tag);
          compare_field("head_valid", TAG_W'(want.head_valid), TAG_W'(out_head_valid));
          compare_field("head_tag", want.head_tag, out_head_tag);
          compare_field("entry_count", TAG_W'(want.entry_count), TAG_W'(out_entry_count));
        end
      end
      if (in_valid && !in_stall)
        queued_results.push_back(apply_request(in_operation, in_new_priority, in_new_tag));
    end
    pending_results <= queued_results.size();
  end

endmodule

// ===== tb/sv/tb_sorted_priority_queue.sv =====
// Top of the sorted priority queue testbench: clock, reset, request stimulus and verdict.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 6;
  localparam int ITEMS_PER_PHASE = 345;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 400000;

  // Operation code 3 is not in the enum; the block treats it as peek.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = ~PRIO_MIN;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation = OP_PEEK;
  logic signed [PRIO_W-1:0] in_new_priority = '0;
  logic [TAG_W-1:0]         in_new_tag = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [TAG_W-1:0]         out_result_tag;
  logic                     out_head_valid;
  logic [TAG_W-1:0]         out_head_tag;
  logic [COUNT_OUT_W-1:0]   out_entry_count;

  int pending_results;
  int fail_count;
  int cycle_count = 0;

  // Idle rates in percent: sender gaps and receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sorted_priority_queue i_dut (.*);

  spq_result_checker i_checker (.*);

  // Stall the result channel at the current rate; a rate of zero gives clean stretches.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Guard against a hang: a lost result or a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it.
  // Insert random sender gaps first; valid only drops between requests.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [PRIO_W-1:0] prio,
                              input logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_new_priority <= prio;
    in_new_tag      <= tag;
    // in_stall read right after the edge still holds its pre-edge value.
    do @(posedge clk); while (in_stall);
  endtask

  // Favor a few small values so ties are common; mix in the extremes and full-range values.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    case ($urandom_range(9))
      0:       return PRIO_MIN;
      1:       return PRIO_MAX;
      2, 3:    return PRIO_W'($urandom);
      default: return PRIO_W'(int'($urandom_range(6)) - 3);
    endcase
  endfunction

  // Hit the edge cases on purpose: empty queue, ties, a new head over two stored
  // entries, extreme priorities and tags, reserved opcode, and offer to a full queue.
  task automatic run_directed();
    int k;
    send_request(OP_PEEK, '0, 16'h1234);
    send_request(OP_POLL, '0, 16'h4321);
    send_request(OP_RESERVED, '0, 16'hBEEF);
    send_request(OP_OFFER, '0, 16'h0000);
    send_request(OP_OFFER, '0, 16'hFFFF);
    send_request(OP_OFFER, PRIO_MAX, 16'h1111);
    send_request(OP_OFFER, PRIO_MIN, 16'h2222);
    send_request(OP_OFFER, PRIO_MAX, 16'h3333);
    send_request(OP_POLL, '0, '0);
    send_request(OP_RESERVED, PRIO_MAX, 16'hFFFF);
    // Fill the remaining slots with spread priorities of both signs.
    for (k = 0; k < 12; k++)
      send_request(OP_OFFER, PRIO_W'(k * 5000 - 30000), TAG_W'(16'hA000 + k));
    send_request(OP_OFFER, PRIO_MAX, 16'h5A5A);
    send_request(OP_PEEK, '0, '0);
    send_request(OP_POLL, '0, '0);
  endtask

  // Alternate fill-leaning and drain-leaning bursts so the queue swings between
  // empty and full instead of hovering in the middle.
  task automatic run_random(input int count);
    int issued;
    int burst;
    int offer_pct;
    int roll;
    logic [OP_W-1:0] op;
    issued = 0;
    while (issued < count) begin
      offer_pct = $urandom_range(1) ? 75 : 25;
      burst = $urandom_range(40, 8);
      while (burst > 0 && issued < count) begin
        roll = $urandom_range(99);
        if (roll < offer_pct)
          op = OP_OFFER;
        else if (roll < 92)
          op = OP_POLL;
        else
          op = $urandom_range(1) ? OP_PEEK : OP_RESERVED;
        send_request(op, pick_priority(), TAG_W'($urandom));
        burst--;
        issued++;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    // Sweep the idle patterns: none, sender gaps, receiver stalls, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 51;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 51;
        end
        default: begin
          idle_pct = 24;
          stall_pct <= 24;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end
    in_valid <= 1'b0;

    // Advance to the next edge so the count includes the last request, then drain.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
